/* design/tccc_pkg.sv */
// Package for the text console cursor controller.
// Holds the result kinds, register indexes, sequencer states and reset constants.
// No dependencies.
`default_nettype none

package tccc_pkg;

  localparam int TAB_STOP_CELLS_DEF = 8;
  localparam int COORD_BITS_DEF     = 16;

  localparam logic [15:0] CHAR_NEWLINE = 16'd10;
  localparam logic [15:0] CHAR_TAB     = 16'd9;

  localparam logic [7:0] GLYPH_WIDTH_RESET  = 8'd8;
  localparam logic [7:0] GLYPH_HEIGHT_RESET = 8'd16;

  typedef enum logic [1:0] {
    KIND_DRAW      = 2'd0,
    KIND_SCROLL    = 2'd1,
    KIND_MOVE      = 2'd2,
    KIND_NOT_READY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_DISPLAY_READY = 3'd0,
    REG_REGION_LEFT   = 3'd1,
    REG_REGION_TOP    = 3'd2,
    REG_REGION_RIGHT  = 3'd3,
    REG_REGION_BOTTOM = 3'd4,
    REG_GLYPH_WIDTH   = 3'd5,
    REG_GLYPH_HEIGHT  = 3'd6,
    REG_TEXT_COLOR    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_SPAN,
    S_DIV_CELL,
    S_MOVE,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* design/tccc_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the tab stop computation of the cursor controller.
// No dependencies.
`default_nettype none

module tccc_div #(
  parameter int DVD_BITS = 16,
  parameter int DVS_BITS = 11
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DVD_BITS-1:0] dividend,
  input  wire logic [DVS_BITS-1:0] divisor,
  output logic                     done,
  output logic [DVD_BITS-1:0]      quotient,
  output logic [DVS_BITS-1:0]      remainder
);

  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   diff;
  logic                ge;

  always_comb begin
    rem_sh = {remainder, quotient[DVD_BITS-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_BITS'(DVD_BITS);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        quotient  <= {quotient[DVD_BITS-2:0], ge};
        remainder <= ge ? diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
        cnt       <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/text_console_cursor_controller_core.sv */
// Sequence: printable and newline results pass the decode and move states before they are
// registered; not-ready results are registered from decode; tab first makes two divider passes.
// Throughput: one character at a time; the next is taken the cycle after its last result
// transfers. A scroll after a draw adds one output transfer.
// Reset: registers return to reset values, cursor to zero; no clearing pass.
// Depends on tccc_pkg and tccc_div.
`default_nettype none

module text_console_cursor_controller_core #(
  parameter int TAB_STOP_CELLS = tccc_pkg::TAB_STOP_CELLS_DEF,
  parameter int COORD_BITS     = tccc_pkg::COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tccc_pkg::kind_t  kind,
  output logic [15:0]      pos_x,
  output logic [15:0]      pos_y,
  output logic [15:0]      glyph_code,
  output logic [31:0]      glyph_color,
  output logic             last
);

  import tccc_pkg::*;

  localparam int CW        = COORD_BITS;
  localparam int WIDE_BITS = (CW > 16) ? CW : 16;
  localparam int SUM_BITS  = WIDE_BITS + 1;
  localparam int STEP_BITS = $clog2(255 * TAB_STOP_CELLS + 1);
  localparam int CELL_BITS = $clog2(TAB_STOP_CELLS + 1);

  state_t state, state_next;

  logic          display_ready;
  logic [15:0]   region_left, region_top, region_right, region_bottom;
  logic [7:0]    glyph_width, glyph_height;
  logic [31:0]   text_color;
  logic [CW-1:0] cursor_x, cursor_y;
  logic [15:0]   code;
  logic [STEP_BITS-1:0] step;
  logic          pending;

  logic          in_xfer, out_xfer, cfg_xfer;
  logic [7:0]    w_eff;
  logic [SUM_BITS-1:0] cx_w, cy_w, left_w, right_w, bottom_w, h_w;
  logic [SUM_BITS-1:0] off_w, adv_x, nx, ny, ny_fin;
  logic [STEP_BITS-1:0] span;
  logic          is_nl, is_tab, drew, scroll;

  logic                 div_start, div_done;
  logic [WIDE_BITS-1:0] div_dividend, div_quotient;
  logic [STEP_BITS-1:0] div_divisor, div_remainder;
  logic [CELL_BITS-1:0] stop_idx;

  function automatic logic [15:0] out16(input logic [CW-1:0] v);
    logic [SUM_BITS-1:0] t;
    t = SUM_BITS'(v);
    return t[15:0];
  endfunction

  tccc_div #(
    .DVD_BITS(WIDE_BITS),
    .DVS_BITS(STEP_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    w_eff    = (glyph_width == 8'd0) ? 8'd1 : glyph_width;
    cx_w     = SUM_BITS'(cursor_x);
    cy_w     = SUM_BITS'(cursor_y);
    left_w   = SUM_BITS'(region_left);
    right_w  = SUM_BITS'(region_right);
    bottom_w = SUM_BITS'(region_bottom);
    h_w      = SUM_BITS'(glyph_height);
    off_w    = (cx_w >= left_w) ? cx_w - left_w : '0;
    span     = STEP_BITS'(int'(w_eff) * TAB_STOP_CELLS);
    stop_idx = div_quotient[CELL_BITS-1:0];
    is_nl    = code == CHAR_NEWLINE;
    is_tab   = code == CHAR_TAB;
    drew     = !is_nl && !is_tab;
    adv_x    = cx_w + SUM_BITS'(step);
    if (is_nl) begin
      nx = left_w;
      ny = cy_w + h_w;
    end else if (adv_x >= right_w) begin
      nx = left_w;
      ny = cy_w + h_w;
    end else begin
      nx = adv_x;
      ny = cy_w;
    end
    scroll = ny >= bottom_w;
    if (!scroll) begin
      ny_fin = ny;
    end else if (bottom_w >= h_w) begin
      ny_fin = bottom_w - h_w;
    end else begin
      ny_fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = state != S_IDLE;
    div_start    = 1'b0;
    div_dividend = off_w[WIDE_BITS-1:0];
    div_divisor  = span;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!display_ready) begin
          state_next = S_OUT;
        end else if (is_tab) begin
          div_start  = 1'b1;
          state_next = S_DIV_SPAN;
        end else begin
          state_next = S_MOVE;
        end
      end
      S_DIV_SPAN: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = WIDE_BITS'(div_remainder);
          div_divisor  = STEP_BITS'(w_eff);
          state_next   = S_DIV_CELL;
        end
      end
      S_DIV_CELL: begin
        if (div_done) begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_xfer && !pending) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_ready <= 1'b0;
      region_left   <= '0;
      region_top    <= '0;
      region_right  <= '0;
      region_bottom <= '0;
      glyph_width   <= GLYPH_WIDTH_RESET;
      glyph_height  <= GLYPH_HEIGHT_RESET;
      text_color    <= '0;
      cursor_x      <= '0;
      cursor_y      <= '0;
      out_valid     <= 1'b0;
      pending       <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        unique case (cfg_index)
          REG_DISPLAY_READY: display_ready <= cfg_data[0];
          REG_REGION_LEFT: begin
            region_left <= cfg_data[15:0];
            cursor_x    <= CW'(cfg_data[15:0]);
            cursor_y    <= CW'(region_top);
          end
          REG_REGION_TOP: begin
            region_top <= cfg_data[15:0];
            cursor_x   <= CW'(region_left);
            cursor_y   <= CW'(cfg_data[15:0]);
          end
          REG_REGION_RIGHT: begin
            region_right <= cfg_data[15:0];
            cursor_x     <= CW'(region_left);
            cursor_y     <= CW'(region_top);
          end
          REG_REGION_BOTTOM: begin
            region_bottom <= cfg_data[15:0];
            cursor_x      <= CW'(region_left);
            cursor_y      <= CW'(region_top);
          end
          REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[7:0];
          REG_GLYPH_HEIGHT: glyph_height <= cfg_data[7:0];
          REG_TEXT_COLOR:   text_color   <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            code <= char_code;
          end
        end
        S_DECODE: begin
          step <= STEP_BITS'(w_eff);
          if (!display_ready) begin
            out_valid   <= 1'b1;
            kind        <= KIND_NOT_READY;
            pos_x       <= out16(cursor_x);
            pos_y       <= out16(cursor_y);
            glyph_code  <= '0;
            glyph_color <= '0;
            last        <= 1'b1;
            pending     <= 1'b0;
          end
        end
        S_DIV_SPAN: ;
        S_DIV_CELL: begin
          if (div_done) begin
            step <= STEP_BITS'((TAB_STOP_CELLS - int'(stop_idx)) * int'(w_eff));
          end
        end
        S_MOVE: begin
          cursor_x  <= nx[CW-1:0];
          cursor_y  <= ny_fin[CW-1:0];
          out_valid <= 1'b1;
          pending   <= drew && scroll;
          if (drew) begin
            kind        <= KIND_DRAW;
            pos_x       <= out16(cursor_x);
            pos_y       <= out16(cursor_y);
            glyph_code  <= code;
            glyph_color <= text_color;
            last        <= !scroll;
          end else begin
            kind        <= scroll ? KIND_SCROLL : KIND_MOVE;
            pos_x       <= out16(nx[CW-1:0]);
            pos_y       <= out16(ny_fin[CW-1:0]);
            glyph_code  <= '0;
            glyph_color <= '0;
            last        <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (pending) begin
              pending     <= 1'b0;
              kind        <= KIND_SCROLL;
              pos_x       <= out16(cursor_x);
              pos_y       <= out16(cursor_y);
              glyph_code  <= '0;
              glyph_color <= '0;
              last        <= 1'b1;
            end else begin
              out_valid <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
